// ----- hw/rtl/pdb_pkg.sv -----
// Shared constants, types and the series divisor table for the phase-difference bearing block.
package pdb_pkg;

  localparam int LANES           = 4;
  localparam int NUM_SENSORS_DEF = 5;

  localparam int PHASE_W   = 16;
  localparam int DIFF_W    = 17;
  localparam int GAIN_W    = 16;
  localparam int PROD_W    = 32;
  localparam int MAG_W     = 13;
  localparam int RATIO_W   = 14;
  localparam int ANGLE_W   = 16;
  localparam int ASIN_W    = 15;
  localparam int S_TDATA_W = 80;
  localparam int M_TDATA_W = 128;

  localparam logic [GAIN_W-1:0] GAIN_RESET  = 16'd8887;
  localparam logic [MAG_W-1:0]  RATIO_LIMIT = 13'd4096;

  // Arcsine table: one entry per ratio magnitude 0..4096.
  localparam int ROM_DEPTH = 4097;
  localparam int ROM_AW    = $clog2(ROM_DEPTH);

  // Boundary index k runs over 1..16384.
  localparam int              K_W    = 15;
  localparam logic [K_W-1:0]  K_LAST = 15'd16384;

  localparam logic [63:0] ONE_Q60     = 64'h1000_0000_0000_0000;
  localparam logic [45:0] PI_Q44_INT  = 46'h3243_F6A8_885A;
  localparam logic [13:0] PI_Q44_FRAC = 14'h308D;

  localparam int                 TERM_W       = 4;
  localparam logic [TERM_W-1:0]  SERIES_TERMS = 4'd12;
  localparam int                 DIVISOR_W    = 10;

  // Divisor (2n)(2n+1) of the sine series term n.
  function automatic logic [DIVISOR_W-1:0] series_divisor(input logic [TERM_W-1:0] n);
    logic [DIVISOR_W-1:0] d;
    unique case (n)
      4'd1:    d = 10'd6;
      4'd2:    d = 10'd20;
      4'd3:    d = 10'd42;
      4'd4:    d = 10'd72;
      4'd5:    d = 10'd110;
      4'd6:    d = 10'd156;
      4'd7:    d = 10'd210;
      4'd8:    d = 10'd272;
      4'd9:    d = 10'd342;
      4'd10:   d = 10'd420;
      4'd11:   d = 10'd506;
      4'd12:   d = 10'd600;
      default: d = 10'd1;
    endcase
    return d;
  endfunction

  typedef struct packed {
    logic s1;
    logic s2;
    logic s3;
  } lane_en_t;

  typedef struct packed {
    logic [MAG_W-1:0] mag;
    logic             neg;
    logic             clamp;
  } lane_res_t;

endpackage

// ----- hw/rtl/phase_difference_bearing.sv -----
// Phase-difference bearing: four lanes of ratio and arcsine bearing per phase set.
//
// Input stream s_*: one transfer carries five phases (pi/32768 units); the last
// is the reference. Output stream m_*: one transfer per input with four Q12
// path-difference ratios, four bearings and a saturation mask. cfg_*: writes
// the Q4.12 gain half_wave_over_radius; it is always ready and should only be
// written while no phase set is in flight.
//
// One phase set can enter every cycle while the table build is done and m_tready
// does not hold the pipeline. The five register stages are: difference, gain multiply,
// round and saturate, arcsine table read, sign and output register.
//
// Reset clears the pipeline, sets the gain to 8887 and rebuilds the arcsine
// table in RAM. The build evaluates every sine boundary on a shared iterative
// unit, so s_tready stays low until the build is done; configuration writes
// are still taken.
//
// When m_tready is low the output register holds its result; earlier stages
// keep accepting until each holds an item, then s_tready falls.
module phase_difference_bearing #(
  parameter int NUM_SENSORS = pdb_pkg::NUM_SENSORS_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  // phase_0, phase_1, phase_2, phase_3, phase_ref (16 bits each)
  input  logic [pdb_pkg::S_TDATA_W-1:0]   s_tdata,
  output logic                            m_tvalid,
  input  logic                            m_tready,
  // ratio_0..ratio_3 (14 bits each), angle_0..angle_3 (16 bits each), clamp_mask (4)
  output logic [pdb_pkg::M_TDATA_W-1:0]   m_tdata,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [pdb_pkg::GAIN_W-1:0]      cfg_data
);
  import pdb_pkg::*;

  logic [GAIN_W-1:0] gain;
  logic              v1, v2, v3, v4, v5;
  logic              en1, en2, en3, en4, en5;
  logic              fill_done;
  logic              fill_we;
  logic [ROM_AW-1:0] fill_waddr;
  logic [ASIN_W-1:0] fill_wdata;
  lane_en_t          lane_en;

  lane_res_t                 res   [LANES];
  logic [ASIN_W-1:0]         asin4 [LANES];
  logic signed [RATIO_W-1:0] ratio4[LANES];
  logic                      neg4  [LANES];
  logic                      clamp4[LANES];
  logic signed [RATIO_W-1:0] ratio5[LANES];
  logic signed [ANGLE_W-1:0] angle5[LANES];
  logic [LANES-1:0]          clamp5;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      gain <= GAIN_RESET;
    end else if (cfg_valid) begin
      gain <= cfg_data;
    end
  end

  // Each stage advances when it is empty or the stage after it advances.
  assign en5      = !v5 || m_tready;
  assign en4      = !v4 || en5;
  assign en3      = !v3 || en4;
  assign en2      = !v2 || en3;
  assign en1      = !v1 || en2;
  assign s_tready = en1 && fill_done;
  assign m_tvalid = v5;
  assign lane_en  = '{s1: en1, s2: en2, s3: en3};

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      v5 <= 1'b0;
    end else begin
      if (en1) v1 <= s_tvalid && s_tready;
      if (en2) v2 <= v1;
      if (en3) v3 <= v2;
      if (en4) v4 <= v3;
      if (en5) v5 <= v4;
    end
  end

  pdb_fill u_fill (
    .clk   (clk),
    .rst   (rst),
    .done  (fill_done),
    .we    (fill_we),
    .waddr (fill_waddr),
    .wdata (fill_wdata)
  );

  for (genvar i = 0; i < LANES; i++) begin : g_lane
    localparam bit ACTIVE = (i < NUM_SENSORS - 1);

    pdb_lane u_lane (
      .clk       (clk),
      .phase     (s_tdata[i*PHASE_W +: PHASE_W]),
      .phase_ref (s_tdata[LANES*PHASE_W +: PHASE_W]),
      .gain      (gain),
      .en        (lane_en),
      .res       (res[i])
    );

    always_ff @(posedge clk) begin
      if (en4) begin
        ratio4[i] <= res[i].neg ? -$signed({1'b0, res[i].mag}) : $signed({1'b0, res[i].mag});
        neg4[i]   <= res[i].neg;
        clamp4[i] <= res[i].clamp;
      end
      if (en5) begin
        if (ACTIVE) begin
          ratio5[i] <= ratio4[i];
          angle5[i] <= neg4[i] ? -$signed({1'b0, asin4[i]}) : $signed({1'b0, asin4[i]});
          clamp5[i] <= clamp4[i];
        end else begin
          ratio5[i] <= '0;
          angle5[i] <= '0;
          clamp5[i] <= 1'b0;
        end
      end
    end
  end

  // Two table copies give four read ports, one per lane.
  for (genvar j = 0; j < LANES / 2; j++) begin : g_rom
    pdb_ram #(
      .WIDTH (ASIN_W),
      .DEPTH (ROM_DEPTH)
    ) u_rom (
      .clk     (clk),
      .we      (fill_we),
      .waddr   (fill_waddr),
      .wdata   (fill_wdata),
      .re      (en4),
      .raddr_a (res[2*j].mag),
      .raddr_b (res[2*j+1].mag),
      .rdata_a (asin4[2*j]),
      .rdata_b (asin4[2*j+1])
    );
  end

  always_comb begin
    m_tdata = '0;
    for (int i = 0; i < LANES; i++) begin
      m_tdata[i*RATIO_W +: RATIO_W]                 = ratio5[i];
      m_tdata[LANES*RATIO_W + i*ANGLE_W +: ANGLE_W] = angle5[i];
    end
    m_tdata[LANES*(RATIO_W+ANGLE_W) +: LANES] = clamp5;
  end

endmodule

// ----- hw/rtl/pdb_ram.sv -----
// Generic RAM with one write port and two registered read ports.
module pdb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr_a,
  input  logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic [WIDTH-1:0]         rdata_a,
  output logic [WIDTH-1:0]         rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_a <= mem[raddr_a];
      rdata_b <= mem[raddr_b];
    end
  end

endmodule

// ----- hw/rtl/pdb_sine.sv -----
// Sequential Q60 sine unit: sin((2k-1)*pi/65536) by a Horner series on one 32x32 multiplier.
module pdb_sine (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   start,
  input  logic [pdb_pkg::K_W-1:0] k,
  output logic                   done,
  output logic [63:0]            sine
);
  import pdb_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE, ST_SQ_SETUP, ST_SQ, ST_T_SETUP, ST_STEP,
    ST_DIV_SETUP, ST_DIV, ST_UPD, ST_FIN, ST_OUT
  } state_t;

  state_t              state;
  logic [63:0]         th;
  logic [63:0]         t;
  logic [63:0]         mul_a;
  logic [63:0]         mul_b;
  logic [127:0]        acc;
  logic [63:0]         pp;
  logic [1:0]          pp_sh;
  logic [2:0]          mcnt;
  logic [63:0]         quo;
  logic [DIVISOR_W-1:0] rem;
  logic [2:0]          dcnt;
  logic [TERM_W-1:0]   n;

  logic [K_W-1:0]       km1;
  logic [14:0]          m;
  logic [60:0]          th_int;
  logic [28:0]          th_frac;
  logic [63:0]          th_calc;
  logic [31:0]          a_half;
  logic [31:0]          b_half;
  logic [63:0]          pp_prod;
  logic [127:0]         pp_shifted;
  logic [63:0]          mul_res;
  logic                 mul_run;
  logic                 mul_last;
  logic [DIVISOR_W-1:0] divisor;
  logic [DIVISOR_W-1:0] rem_next;
  logic [63:0]          quo_next;

  // Angle in Q60: m*pi with pi held as Q44 plus 16 more fraction bits.
  assign km1     = k - K_W'(1);
  assign m       = {km1[13:0], 1'b1};
  assign th_int  = 61'(m) * 61'(PI_Q44_INT);
  assign th_frac = 29'(m) * 29'(PI_Q44_FRAC);
  assign th_calc = 64'(th_int) + 64'(th_frac[28:16]);

  // One 32x32 partial product per cycle, registered and added to the accumulator in the next cycle.
  assign a_half   = mcnt[1] ? mul_a[63:32] : mul_a[31:0];
  assign b_half   = mcnt[0] ? mul_b[63:32] : mul_b[31:0];
  assign pp_prod  = a_half * b_half;
  assign mul_res  = acc[123:60];
  assign mul_run  = (state == ST_SQ) || (state == ST_STEP) || (state == ST_FIN);
  assign mul_last = (mcnt == 3'd4);

  always_comb begin
    case (pp_sh)
      2'd0:    pp_shifted = {64'b0, pp};
      2'd1:    pp_shifted = {32'b0, pp, 32'b0};
      default: pp_shifted = {pp, 64'b0};
    endcase
  end

  // Long division by a small constant, eight quotient bits per cycle.
  assign divisor = series_divisor(n);

  always_comb begin
    logic [DIVISOR_W:0] rem_v;
    logic [63:0]        quo_v;
    rem_v = {1'b0, rem};
    quo_v = quo;
    for (int i = 0; i < 8; i++) begin
      rem_v = {rem_v[DIVISOR_W-1:0], quo_v[63]};
      quo_v = {quo_v[62:0], 1'b0};
      if (rem_v >= {1'b0, divisor}) begin
        rem_v    = rem_v - {1'b0, divisor};
        quo_v[0] = 1'b1;
      end
    end
    rem_next = rem_v[DIVISOR_W-1:0];
    quo_next = quo_v;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      if (mul_run) begin
        if (!mcnt[2]) begin
          pp    <= pp_prod;
          pp_sh <= {1'b0, mcnt[1]} + {1'b0, mcnt[0]};
        end
        if (mcnt != 3'd0) begin
          acc <= acc + pp_shifted;
        end
        mcnt <= mcnt + 3'd1;
      end
      unique case (state)
        ST_IDLE: begin
          if (start) begin
            th    <= th_calc;
            state <= ST_SQ_SETUP;
          end
        end
        ST_SQ_SETUP: begin
          mul_a <= th;
          mul_b <= th;
          acc   <= '0;
          mcnt  <= '0;
          state <= ST_SQ;
        end
        ST_SQ: begin
          if (mul_last) begin
            state <= ST_T_SETUP;
          end
        end
        ST_T_SETUP: begin
          t     <= mul_res;
          mul_a <= mul_res;
          mul_b <= ONE_Q60;
          acc   <= '0;
          mcnt  <= '0;
          n     <= SERIES_TERMS;
          state <= ST_STEP;
        end
        ST_STEP: begin
          if (mul_last) begin
            state <= ST_DIV_SETUP;
          end
        end
        ST_DIV_SETUP: begin
          quo   <= mul_res;
          rem   <= '0;
          dcnt  <= '0;
          state <= ST_DIV;
        end
        ST_DIV: begin
          quo  <= quo_next;
          rem  <= rem_next;
          dcnt <= dcnt + 3'd1;
          if (dcnt == 3'd7) begin
            state <= ST_UPD;
          end
        end
        ST_UPD: begin
          mul_b <= ONE_Q60 - quo;
          acc   <= '0;
          mcnt  <= '0;
          n     <= n - TERM_W'(1);
          if (n == TERM_W'(1)) begin
            mul_a <= th;
            state <= ST_FIN;
          end else begin
            mul_a <= t;
            state <= ST_STEP;
          end
        end
        ST_FIN: begin
          if (mul_last) begin
            state <= ST_OUT;
          end
        end
        ST_OUT: begin
          sine  <= mul_res;
          done  <= 1'b1;
          state <= ST_IDLE;
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

// ----- hw/rtl/pdb_fill.sv -----
// Arcsine table builder: walks the sine boundaries and writes round(asin) for every ratio.
module pdb_fill (
  input  logic                        clk,
  input  logic                        rst,
  output logic                        done,
  output logic                        we,
  output logic [pdb_pkg::ROM_AW-1:0]  waddr,
  output logic [pdb_pkg::ASIN_W-1:0]  wdata
);
  import pdb_pkg::*;

  typedef enum logic [1:0] {F_START, F_WAIT, F_CMP, F_DONE} state_t;

  localparam logic [ROM_AW-1:0] F_LAST = ROM_AW'(ROM_DEPTH - 1);

  state_t            state;
  logic [K_W-1:0]    k;
  logic [ROM_AW-1:0] f;
  logic [63:0]       s_cur;

  logic        sine_done;
  logic [63:0] sine_val;
  logic [63:0] x;
  logic        k_in_range;

  pdb_sine u_sine (
    .clk   (clk),
    .rst   (rst),
    .start (state == F_START),
    .k     (k),
    .done  (sine_done),
    .sine  (sine_val)
  );

  // The table entry for ratio f counts the boundaries at or below f/4096.
  assign x          = {3'b0, f, 48'b0};
  assign k_in_range = (k <= K_LAST);
  assign done       = (state == F_DONE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= F_START;
      k     <= K_W'(1);
      f     <= '0;
      we    <= 1'b0;
    end else begin
      we <= 1'b0;
      unique case (state)
        F_START: state <= F_WAIT;
        F_WAIT: begin
          if (sine_done) begin
            s_cur <= sine_val;
            state <= F_CMP;
          end
        end
        F_CMP: begin
          if (k_in_range && (s_cur <= x)) begin
            k <= k + K_W'(1);
            if (k != K_LAST) begin
              state <= F_START;
            end
          end else begin
            we    <= 1'b1;
            waddr <= f;
            wdata <= ASIN_W'(k - K_W'(1));
            if (f == F_LAST) begin
              state <= F_DONE;
            end else begin
              f <= f + ROM_AW'(1);
            end
          end
        end
        F_DONE: state <= F_DONE;
        default: state <= F_START;
      endcase
    end
  end

endmodule

// ----- hw/rtl/pdb_lane.sv -----
// One lane front end: wrapped phase difference, gain multiply, round and saturate.
module pdb_lane (
  input  logic                                clk,
  input  logic signed [pdb_pkg::PHASE_W-1:0]  phase,
  input  logic signed [pdb_pkg::PHASE_W-1:0]  phase_ref,
  input  logic [pdb_pkg::GAIN_W-1:0]          gain,
  input  pdb_pkg::lane_en_t                   en,
  output pdb_pkg::lane_res_t                  res
);
  import pdb_pkg::*;

  logic signed [DIFF_W-1:0] d;
  logic signed [PROD_W-1:0] p;

  logic [PHASE_W-1:0]         diff;
  logic signed [DIFF_W-1:0]   d_calc;
  logic signed [2*DIFF_W-1:0] prod_full;
  logic [PROD_W-1:0]          p_neg;
  logic [PROD_W-2:0]          mag;
  logic [PROD_W-2:0]          rnd;
  logic [15:0]                r_full;
  logic                       over;

  // A difference of exactly -pi is taken as +pi.
  assign diff   = phase - phase_ref;
  assign d_calc = (diff == 16'h8000) ? {1'b0, diff} : {diff[PHASE_W-1], diff};

  assign prod_full = $signed({1'b0, gain}) * d;

  // Round half away from zero on the magnitude, then saturate to one radius.
  assign p_neg  = -p;
  assign mag    = p[PROD_W-1] ? p_neg[PROD_W-2:0] : p[PROD_W-2:0];
  assign rnd    = mag + 31'd16384;
  assign r_full = rnd[30:15];
  assign over   = (r_full > {3'b0, RATIO_LIMIT});

  always_ff @(posedge clk) begin
    if (en.s1) begin
      d <= d_calc;
    end
    if (en.s2) begin
      p <= prod_full[PROD_W-1:0];
    end
    if (en.s3) begin
      res.mag   <= over ? RATIO_LIMIT : r_full[MAG_W-1:0];
      res.neg   <= p[PROD_W-1];
      res.clamp <= over;
    end
  end

endmodule

// ----- hw/rtl/pdb_checker.sv -----
// Port-level checks for the phase-difference bearing block, bound to the top level.
module pdb_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          s_tready,
  input logic                          m_tvalid,
  input logic                          m_tready,
  input logic [pdb_pkg::M_TDATA_W-1:0] m_tdata
);
  import pdb_pkg::*;

  // Reset empties the pipeline and starts the table build.
  a_reset: assert property (@(posedge clk) rst |=> !m_tvalid && !s_tready)
    else $error("output valid or input ready right after reset");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("stalled result changed");

  // A saturated lane 0 must report a full-radius ratio.
  a_clamp: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[LANES*(RATIO_W+ANGLE_W)] |->
      m_tdata[RATIO_W-1:0] == 14'h1000 || m_tdata[RATIO_W-1:0] == 14'h3000)
    else $error("clamp flag without saturated ratio");

  // The table read must agree with the ratio: zero only at zero, same sign.
  a_angle: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |->
      ((m_tdata[RATIO_W-1:0] == 14'h0) == (m_tdata[LANES*RATIO_W +: ANGLE_W] == 16'h0)) &&
      (m_tdata[RATIO_W-1] == m_tdata[LANES*RATIO_W + ANGLE_W - 1]))
    else $error("bearing does not match ratio on lane 0");

endmodule

bind phase_difference_bearing pdb_checker u_pdb_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);
